FILE: sv/table_driven_token_lexer_defines.svh
// Assertion macros for the token lexer.
// Each macro takes a label, the clock, the reset and two expressions.
`ifndef TABLE_DRIVEN_TOKEN_LEXER_DEFINES_SVH
`define TABLE_DRIVEN_TOKEN_LEXER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TDL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdl: same-cycle check failed");
// Next-cycle implication.
`define TDL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdl: next-cycle check failed");
`else
`define TDL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TDL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/tdl_pkg.sv
package tdl_pkg;

  localparam int NUM_STATES  = 26;
  localparam int NUM_CLASSES = 9;

  // Character classes, in table column order.
  typedef enum logic [3:0] {
    CLS_LETTER = 4'd0,
    CLS_DIGIT  = 4'd1,
    CLS_COLON  = 4'd2,
    CLS_SLASH  = 4'd3,
    CLS_SPACE  = 4'd4,
    CLS_SEMI   = 4'd5,
    CLS_OTHER  = 4'd6,
    CLS_DOLLAR = 4'd7,
    CLS_HASH   = 4'd8
  } cls_t;

  // One classified character, passed from the front to the back.
  typedef struct packed {
    cls_t       cls;
    logic [4:0] val;
    logic       line_start;
  } item_t;

  // Character codes.
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;

  // Token classes on the result channel.
  localparam logic [3:0] TOK_END        = 4'd0;
  localparam logic [3:0] TOK_WORD       = 4'd1;
  localparam logic [3:0] TOK_NUMBER     = 4'd2;
  localparam logic [3:0] TOK_UNKNOWN    = 4'd3;
  localparam logic [3:0] TOK_DATE       = 4'd4;
  localparam logic [3:0] TOK_PLATE      = 4'd5;
  localparam logic [3:0] TOK_TIME       = 4'd6;
  localparam logic [3:0] TOK_ENTRY      = 4'd7;
  localparam logic [3:0] TOK_EXIT       = 4'd8;
  localparam logic [3:0] TOK_WORD_ERR   = 4'd9;
  localparam logic [3:0] TOK_NUMBER_ERR = 4'd10;
  localparam logic [3:0] TOK_PLATE_ERR  = 4'd11;
  localparam logic [3:0] TOK_TIME_ERR   = 4'd12;
  localparam logic [3:0] TOK_DATE_ERR   = 4'd13;

  // Fixed values loaded on entry to unknown, marker and error states.
  localparam logic [31:0] LOAD_UNKNOWN    = 32'hFFFF_FFE7;  // -25
  localparam logic [31:0] LOAD_ENTRY      = 32'hFFFF_FFEC;  // -20
  localparam logic [31:0] LOAD_EXIT       = 32'hFFFF_FFF1;  // -15
  localparam logic [31:0] LOAD_WORD_ERR   = 32'hFFFF_FFE2;  // -30
  localparam logic [31:0] LOAD_NUMBER_ERR = 32'hFFFF_FFDD;  // -35
  localparam logic [31:0] LOAD_PLATE_ERR  = 32'hFFFF_FFD8;  // -40
  localparam logic [31:0] LOAD_TIME_ERR   = 32'hFFFF_FFD3;  // -45
  localparam logic [31:0] LOAD_DATE_ERR   = 32'hFFFF_FFCE;  // -50

  // Transition table. A positive entry is the next state, zero stays idle,
  // and a negative entry ends the token with the class found in END_CLASS.
  // Columns: letter, digit, ':', '/', space, ';', other, '$', '#'.
  localparam logic signed [5:0] NEXT_TAB [NUM_STATES][NUM_CLASSES] = '{
    '{ 6'sd1,  6'sd2,  6'sd4,  6'sd4,  6'sd0,  -6'sd10, 6'sd4,  6'sd19, 6'sd20},
    '{ 6'sd1,  6'sd21, 6'sd21, 6'sd21, -6'sd1, -6'sd1,  6'sd21, 6'sd21, 6'sd21},
    '{ 6'sd22, 6'sd3,  6'sd22, 6'sd22, -6'sd2, -6'sd2,  6'sd22, 6'sd22, 6'sd22},
    '{ 6'sd5,  6'sd8,  6'sd6,  6'sd7,  -6'sd2, -6'sd2,  6'sd22, 6'sd22, 6'sd22},
    '{ 6'sd4,  6'sd4,  6'sd4,  6'sd4,  -6'sd3, -6'sd3,  6'sd4,  6'sd4,  6'sd4},
    '{ 6'sd9,  6'sd23, 6'sd23, 6'sd23, -6'sd3, -6'sd3,  6'sd23, 6'sd23, 6'sd23},
    '{ 6'sd24, 6'sd10, 6'sd24, 6'sd24, -6'sd3, -6'sd3,  6'sd24, 6'sd24, 6'sd24},
    '{ 6'sd25, 6'sd11, 6'sd25, 6'sd25, -6'sd3, -6'sd3,  6'sd25, 6'sd25, 6'sd25},
    '{ 6'sd22, 6'sd8,  6'sd22, 6'sd22, -6'sd2, -6'sd2,  6'sd22, 6'sd22, 6'sd22},
    '{ 6'sd23, 6'sd12, 6'sd23, 6'sd23, -6'sd3, -6'sd3,  6'sd23, 6'sd23, 6'sd23},
    '{ 6'sd24, 6'sd13, 6'sd24, 6'sd24, -6'sd3, -6'sd3,  6'sd24, 6'sd24, 6'sd24},
    '{ 6'sd25, 6'sd14, 6'sd25, 6'sd25, -6'sd3, -6'sd3,  6'sd25, 6'sd25, 6'sd25},
    '{ 6'sd23, 6'sd15, 6'sd23, 6'sd23, -6'sd3, -6'sd3,  6'sd23, 6'sd23, 6'sd23},
    '{ 6'sd24, 6'sd24, 6'sd24, 6'sd24, -6'sd7, -6'sd7,  6'sd24, 6'sd24, 6'sd24},
    '{ 6'sd25, 6'sd25, 6'sd25, 6'sd16, -6'sd3, -6'sd3,  6'sd25, 6'sd25, 6'sd25},
    '{ 6'sd23, 6'sd23, 6'sd23, 6'sd23, -6'sd6, -6'sd6,  6'sd23, 6'sd23, 6'sd23},
    '{ 6'sd25, 6'sd17, 6'sd25, 6'sd25, -6'sd3, -6'sd3,  6'sd25, 6'sd25, 6'sd25},
    '{ 6'sd25, 6'sd18, 6'sd25, 6'sd25, -6'sd3, -6'sd3,  6'sd25, 6'sd25, 6'sd25},
    '{ 6'sd25, 6'sd25, 6'sd25, 6'sd25, -6'sd5, -6'sd5,  6'sd25, 6'sd25, 6'sd25},
    '{ 6'sd4,  6'sd4,  6'sd4,  6'sd4,  -6'sd8, -6'sd8,  6'sd4,  6'sd4,  6'sd4},
    '{ 6'sd4,  6'sd4,  6'sd4,  6'sd4,  -6'sd9, -6'sd9,  6'sd4,  6'sd4,  6'sd4},
    '{ 6'sd21, 6'sd21, 6'sd21, 6'sd21, -6'sd11, -6'sd11, 6'sd21, 6'sd21, 6'sd21},
    '{ 6'sd22, 6'sd22, 6'sd22, 6'sd22, -6'sd12, -6'sd12, 6'sd22, 6'sd22, 6'sd22},
    '{ 6'sd23, 6'sd23, 6'sd23, 6'sd23, -6'sd13, -6'sd13, 6'sd23, 6'sd23, 6'sd23},
    '{ 6'sd24, 6'sd24, 6'sd24, 6'sd24, -6'sd14, -6'sd14, 6'sd24, 6'sd24, 6'sd24},
    '{ 6'sd25, 6'sd25, 6'sd25, 6'sd25, -6'sd15, -6'sd15, 6'sd25, 6'sd25, 6'sd25}
  };

  // Token class for an ending code, indexed by its magnitude.
  localparam logic [3:0] END_CLASS [16] = '{
    TOK_END, TOK_WORD, TOK_NUMBER, TOK_UNKNOWN, TOK_END, TOK_DATE, TOK_PLATE,
    TOK_TIME, TOK_ENTRY, TOK_EXIT, TOK_END, TOK_WORD_ERR, TOK_NUMBER_ERR,
    TOK_PLATE_ERR, TOK_TIME_ERR, TOK_DATE_ERR
  };

endpackage

FILE: sv/table_driven_token_lexer.sv
// Channel  Handshake            Payload
// input    in_valid/in_ready    char_code, line_start
// output   out_valid/out_ready  token_class, token_value
//
// One character is taken per cycle while the output is not stalled; a token's
// ending character passes through the classifier register, queue and result register.
// The scanner state and accumulator update once per character in the back stage.
// Reset clears the valid flags, queue pointers and scanner state.
// A stalled output fills the queue, and only then is in_ready dropped.
`include "table_driven_token_lexer_defines.svh"

module table_driven_token_lexer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_code,
  input  logic               line_start,
  input  logic               in_valid,
  output logic               in_ready,
  output logic [3:0]         token_class,
  output logic signed [31:0] token_value,
  output logic               out_valid,
  input  logic               out_ready
);

  tdl_pkg::item_t f_item;
  logic           f_valid;
  logic           f_ready;
  tdl_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;

  // Classify characters.
  tdl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .line_start (line_start),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  // Decouple the classifier from the scanner.
  tdl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (f_item),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // Run the transition table and build tokens.
  tdl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (q_item),
    .item_valid  (q_valid),
    .item_ready  (q_ready),
    .token_class (token_class),
    .token_value (token_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  // A stalled result blocks the scanner from consuming another character.
  `TDL_ASSERT_IMP(a_stall_blocks_pop, clk, rst, out_valid && !out_ready, !(q_valid && q_ready))
  // An end token always carries a zero value.
  `TDL_ASSERT_IMP(a_end_zero, clk, rst, out_valid && token_class == tdl_pkg::TOK_END, token_value == 32'sd0)
  // Token classes stay within the defined set.
  `TDL_ASSERT_IMP(a_class_range, clk, rst, out_valid, token_class <= tdl_pkg::TOK_DATE_ERR)
  // A ';' that starts a line yields an end token on the next cycle.
  `TDL_ASSERT_NEXT(a_line_semi, clk, rst, q_valid && q_ready && q_item.line_start && q_item.cls == tdl_pkg::CLS_SEMI, out_valid && token_class == tdl_pkg::TOK_END)

endmodule

FILE: sv/tdl_front.sv
module tdl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    char_code,
  input  logic          line_start,
  input  logic          in_valid,
  output logic          in_ready,
  output tdl_pkg::item_t item,
  output logic          item_valid,
  input  logic          item_ready
);

  tdl_pkg::item_t item_next;

  // Sort the character into its class and take its letter or digit offset.
  always_comb begin
    item_next.line_start = line_start;
    item_next.val        = 5'd0;
    case (char_code) inside
      [tdl_pkg::CH_A:tdl_pkg::CH_Z]: begin
        item_next.cls = tdl_pkg::CLS_LETTER;
        item_next.val = 5'(char_code - tdl_pkg::CH_A);
      end
      [tdl_pkg::CH_0:tdl_pkg::CH_9]: begin
        item_next.cls = tdl_pkg::CLS_DIGIT;
        item_next.val = 5'(char_code - tdl_pkg::CH_0);
      end
      tdl_pkg::CH_COLON:  item_next.cls = tdl_pkg::CLS_COLON;
      tdl_pkg::CH_SLASH:  item_next.cls = tdl_pkg::CLS_SLASH;
      tdl_pkg::CH_SPACE:  item_next.cls = tdl_pkg::CLS_SPACE;
      tdl_pkg::CH_SEMI:   item_next.cls = tdl_pkg::CLS_SEMI;
      tdl_pkg::CH_DOLLAR: item_next.cls = tdl_pkg::CLS_DOLLAR;
      tdl_pkg::CH_HASH:   item_next.cls = tdl_pkg::CLS_HASH;
      default:            item_next.cls = tdl_pkg::CLS_OTHER;
    endcase
  end

  // The stage takes a new transfer whenever it is empty or being drained.
  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

FILE: sv/tdl_fifo.sv
module tdl_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  tdl_pkg::item_t wr_item,
  input  logic           wr_valid,
  output logic           wr_ready,
  output tdl_pkg::item_t rd_item,
  output logic           rd_valid,
  input  logic           rd_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tdl_pkg::item_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

FILE: sv/tdl_back.sv
module tdl_back (
  input  logic               clk,
  input  logic               rst,
  input  tdl_pkg::item_t     item,
  input  logic               item_valid,
  output logic               item_ready,
  output logic [3:0]         token_class,
  output logic signed [31:0] token_value,
  output logic               out_valid,
  input  logic               out_ready
);

  logic [4:0]         scan_state;
  logic [31:0]        acc;
  logic [4:0]         scan_state_next;
  logic [31:0]        acc_next;
  logic [4:0]         cur_state;
  logic [31:0]        cur_acc;
  logic signed [5:0]  code;
  logic [5:0]         neg_code;
  logic               emit;
  logic [4:0]         target;
  logic [31:0]        acc_x26;
  logic [31:0]        acc_x10;
  logic               take;

  // An item is consumed whenever the result register is free or being drained.
  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  // Start of line clears the scanner; unreachable rows fall back to idle.
  always_comb begin
    cur_state = (item.line_start || scan_state >= 5'(tdl_pkg::NUM_STATES)) ? 5'd0
                                                                            : scan_state;
    cur_acc   = item.line_start ? 32'd0 : acc;
    code      = tdl_pkg::NEXT_TAB[cur_state][item.cls];
    neg_code  = 6'(-code);
    emit      = code[5];
    target    = code[4:0];
    acc_x26   = (cur_acc << 4) + (cur_acc << 3) + (cur_acc << 1);
    acc_x10   = (cur_acc << 3) + (cur_acc << 1);
  end

  // Next state and accumulator for each character; one that ends a token returns to idle with a cleared accumulator.
  always_comb begin
    scan_state_next = cur_state;
    acc_next        = cur_acc;
    if (emit) begin
      scan_state_next = 5'd0;
      acc_next        = 32'd0;
    end else if (target != 5'd0) begin
      scan_state_next = target;
      case (target) inside
        5'd1, 5'd5, 5'd9:
          acc_next = acc_x26 + 32'(item.val);
        5'd2, 5'd3, 5'd8, [5'd10:5'd15], 5'd17, 5'd18:
          acc_next = acc_x10 + 32'(item.val);
        5'd4:    acc_next = tdl_pkg::LOAD_UNKNOWN;
        5'd19:   acc_next = tdl_pkg::LOAD_ENTRY;
        5'd20:   acc_next = tdl_pkg::LOAD_EXIT;
        5'd21:   acc_next = tdl_pkg::LOAD_WORD_ERR;
        5'd22:   acc_next = tdl_pkg::LOAD_NUMBER_ERR;
        5'd23:   acc_next = tdl_pkg::LOAD_PLATE_ERR;
        5'd24:   acc_next = tdl_pkg::LOAD_TIME_ERR;
        5'd25:   acc_next = tdl_pkg::LOAD_DATE_ERR;
        default: acc_next = cur_acc;
      endcase
    end
  end

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= 5'd0;
      acc        <= 32'd0;
    end else if (take) begin
      scan_state <= scan_state_next;
      acc        <= acc_next;
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      token_class <= tdl_pkg::END_CLASS[neg_code[3:0]];
      token_value <= cur_acc;
    end
  end

endmodule
